FILE: rtl/assert_macros.svh
// Assertion helpers for the opinion sweep block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge of clk, quiet while arst_n is low.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/sgos_pkg.sv
`timescale 1ns / 1ps
package sgos_pkg;

	localparam int NODES      = 1024;
	localparam int MAX_DEGREE = 16;
	localparam int PROB_BITS  = 16;

	localparam int NODE_W  = 10;
	localparam int SLOT_W  = 4;
	localparam int DEG_W   = 5;
	localparam int CNT_W   = 5;
	localparam int RATE_W  = 17;
	localparam int DRAW_W  = 16;
	localparam int SITE_W  = 11;

	localparam int NBR_DEPTH  = NODES * MAX_DEGREE;
	localparam int NBR_AW     = $clog2(NBR_DEPTH);
	localparam int RATE_DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
	localparam int RATE_AW    = $clog2(RATE_DEPTH);

	localparam logic [RATE_W-1:0] PROB_ONE = RATE_W'(64'd1 << PROB_BITS);

	typedef enum logic [2:0] {
		REQ_NBR    = 3'd0,
		REQ_DEG    = 3'd1,
		REQ_OPIN   = 3'd2,
		REQ_RATE   = 3'd3,
		REQ_UPD    = 3'd4,
		REQ_COMMIT = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEG,
		ST_NBR,
		ST_RATE,
		ST_COMMIT
	} state_t;

	// base of row k in the triangular rate table: k*(k+1)/2
	function automatic logic [RATE_AW-1:0] tri_base(input logic [DEG_W-1:0] k);
		logic [11:0] p;
		p = 12'(k) * (12'(k) + 12'd1);
		return RATE_AW'(p >> 1);
	endfunction

endpackage

FILE: rtl/stochastic_graph_opinion_sweep_core.sv
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// request   | start in, busy out        | req_type .. random_draw
// result    | done out, one cycle       | result_kind, node_out, new_opinion, active_total
// config    | cfg_we in                 | cfg_data (site_count)
//
// Writes are done in the idle state and keep busy low. A node update reads the degree,
// then walks the neighbours, reading one neighbour slot and one opinion per cycle,
// then looks up the rate; a degree-zero node skips the walk and keeps its opinion.
// A commit copies min(site_count,1024) nodes from next to current, one node per cycle.
// After reset a clearing pass zeroes degrees and opinions; busy is high.
// done marks a result for exactly one cycle; the receiver cannot stall it.
`include "assert_macros.svh"
module stochastic_graph_opinion_sweep_core
	import sgos_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cfg_we,
	input  logic [SITE_W-1:0] cfg_data,
	input  logic [2:0]        req_type,
	input  logic [NODE_W-1:0] node_index,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [NODE_W-1:0] neighbour_index,
	input  logic [DEG_W-1:0]  degree_value,
	input  logic [CNT_W-1:0]  count_value,
	input  logic [RATE_W-1:0] rate_value,
	input  logic              opinion_value,
	input  logic [DRAW_W-1:0] random_draw,
	output logic              done,
	output logic              result_kind,
	output logic [NODE_W-1:0] node_out,
	output logic              new_opinion,
	output logic [SITE_W-1:0] active_total
);

	state_t state_q, state_d;

	logic              done_q;
	logic [SITE_W-1:0] site_q;
	logic [NODE_W-1:0] clr_q;
	logic [DEG_W-1:0]  k_q, iss_q, rcv_q, s_q;
	logic              nv_s1, cv_s2, ok_s2;
	logic [NODE_W-1:0] node_q;
	logic [DRAW_W-1:0] draw_q;
	logic [SITE_W-1:0] ci_q, limit_q, tot_q;
	logic              pv_s1;
	logic [NODE_W-1:0] cidx_s1;

	logic              kind_q, opin_q;
	logic [NODE_W-1:0] nout_q;
	logic [SITE_W-1:0] total_q;

	logic              nbr_we;
	logic [NBR_AW-1:0] nbr_waddr, nbr_raddr;
	logic [NODE_W-1:0] nbr_rd;
	logic              deg_we;
	logic [NODE_W-1:0] deg_waddr;
	logic [DEG_W-1:0]  deg_wdata, deg_rd;
	logic              cur_we, cur_wdata, cur_rd;
	logic [NODE_W-1:0] cur_waddr, cur_raddr;
	logic              nxt_we, nxt_wdata, nxt_rd;
	logic [NODE_W-1:0] nxt_waddr, nxt_raddr;
	logic               rate_we;
	logic [RATE_AW-1:0] rate_waddr, rate_raddr;
	logic [RATE_W-1:0]  rate_wdata, rate_rd;

	logic accept, node_ok, issue, cissue, upd_res;
	logic out_upd, out_commit;
	logic out_opin;
	logic [SITE_W-1:0] site_lim;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign node_ok = 32'(node_index) < NODES;
	assign issue   = (iss_q < k_q);
	assign cissue  = (ci_q < limit_q);
	assign upd_res = {1'b0, draw_q} < rate_rd;
	assign site_lim = (32'(site_q) > NODES) ? SITE_W'(NODES) : site_q;

	always_comb begin
		state_d    = state_q;
		nbr_we     = 1'b0;
		nbr_waddr  = NBR_AW'(32'(node_index) * MAX_DEGREE + 32'(slot_index));
		nbr_raddr  = NBR_AW'(32'(node_q) * MAX_DEGREE + 32'(iss_q));
		deg_we     = 1'b0;
		deg_waddr  = node_index;
		deg_wdata  = (32'(degree_value) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : degree_value;
		cur_we     = 1'b0;
		cur_waddr  = node_index;
		cur_wdata  = opinion_value;
		cur_raddr  = node_index;
		nxt_we     = 1'b0;
		nxt_waddr  = node_index;
		nxt_wdata  = opinion_value;
		nxt_raddr  = ci_q[NODE_W-1:0];
		rate_we    = 1'b0;
		rate_waddr = tri_base(degree_value) + RATE_AW'(count_value);
		rate_wdata = (rate_value > PROB_ONE) ? PROB_ONE : rate_value;
		rate_raddr = tri_base(k_q) + RATE_AW'(s_q);
		out_upd    = 1'b0;
		out_commit = 1'b0;
		out_opin   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				deg_we    = 1'b1;
				deg_waddr = clr_q;
				deg_wdata = '0;
				cur_we    = 1'b1;
				cur_waddr = clr_q;
				cur_wdata = 1'b0;
				nxt_we    = 1'b1;
				nxt_waddr = clr_q;
				nxt_wdata = 1'b0;
				if (clr_q == NODE_W'(NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_NBR: begin
							nbr_we = node_ok && (32'(slot_index) < MAX_DEGREE);
						end
						REQ_DEG: begin
							deg_we = node_ok;
						end
						REQ_OPIN: begin
							cur_we = node_ok;
							nxt_we = node_ok;
						end
						REQ_RATE: begin
							rate_we = node_ok && (32'(degree_value) <= MAX_DEGREE)
								&& (count_value <= degree_value);
						end
						REQ_UPD: begin
							if (node_ok) begin
								state_d = ST_DEG;
							end
						end
						REQ_COMMIT: begin
							state_d = ST_COMMIT;
						end
						default: ;
					endcase
				end
			end
			ST_DEG: begin
				if (deg_rd == '0) begin
					nxt_we    = 1'b1;
					nxt_waddr = node_q;
					nxt_wdata = cur_rd;
					out_upd   = 1'b1;
					out_opin  = cur_rd;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_NBR;
				end
			end
			ST_NBR: begin
				cur_raddr = nbr_rd;
				if (rcv_q == k_q) begin
					state_d = ST_RATE;
				end
			end
			ST_RATE: begin
				nxt_we    = 1'b1;
				nxt_waddr = node_q;
				nxt_wdata = upd_res;
				out_upd   = 1'b1;
				out_opin  = upd_res;
				state_d   = ST_IDLE;
			end
			ST_COMMIT: begin
				cur_waddr = cidx_s1;
				cur_wdata = nxt_rd;
				cur_we    = pv_s1;
				if (!cissue && !pv_s1) begin
					out_commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
			site_q  <= SITE_W'(1024);
			clr_q   <= '0;
			iss_q   <= '0;
			rcv_q   <= '0;
			nv_s1   <= 1'b0;
			cv_s2   <= 1'b0;
			ci_q    <= '0;
			pv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= out_upd || out_commit;
			if (cfg_we) begin
				site_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_NBR) begin
				iss_q <= iss_q + DEG_W'(issue);
				nv_s1 <= issue;
				cv_s2 <= nv_s1;
				if (cv_s2) begin
					rcv_q <= rcv_q + 1'b1;
				end
			end else begin
				iss_q <= '0;
				rcv_q <= '0;
				nv_s1 <= 1'b0;
				cv_s2 <= 1'b0;
			end
			if (state_q == ST_COMMIT) begin
				ci_q  <= ci_q + SITE_W'(cissue);
				pv_s1 <= cissue;
			end else begin
				ci_q  <= '0;
				pv_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s2   <= 32'(nbr_rd) < NODES;
		cidx_s1 <= ci_q[NODE_W-1:0];
		if (accept) begin
			node_q  <= node_index;
			draw_q  <= random_draw;
			limit_q <= site_lim;
		end
		if (state_q == ST_DEG) begin
			k_q <= deg_rd;
		end
		if (state_q == ST_NBR) begin
			if (cv_s2) begin
				s_q <= s_q + DEG_W'(ok_s2 & cur_rd);
			end
		end else begin
			s_q <= '0;
		end
		if (state_q == ST_COMMIT) begin
			if (pv_s1) begin
				tot_q <= tot_q + SITE_W'(nxt_rd);
			end
		end else begin
			tot_q <= '0;
		end
		if (out_upd) begin
			kind_q  <= 1'b0;
			nout_q  <= node_q;
			opin_q  <= out_opin;
			total_q <= '0;
		end else if (out_commit) begin
			kind_q  <= 1'b1;
			nout_q  <= '0;
			opin_q  <= 1'b0;
			total_q <= tot_q;
		end
	end

	assign done         = done_q;
	assign result_kind  = kind_q;
	assign node_out     = nout_q;
	assign new_opinion  = opin_q;
	assign active_total = total_q;

	sgos_ram #(.DEPTH(NBR_DEPTH), .WIDTH(NODE_W)) u_nbr (
		.clk   (clk),
		.we    (nbr_we),
		.waddr (nbr_waddr),
		.wdata (neighbour_index),
		.raddr (nbr_raddr),
		.rdata (nbr_rd)
	);

	sgos_ram #(.DEPTH(NODES), .WIDTH(DEG_W)) u_deg (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.raddr (node_index),
		.rdata (deg_rd)
	);

	sgos_ram #(.DEPTH(NODES), .WIDTH(1)) u_cur (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (cur_raddr),
		.rdata (cur_rd)
	);

	sgos_ram #(.DEPTH(NODES), .WIDTH(1)) u_nxt (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (nxt_raddr),
		.rdata (nxt_rd)
	);

	sgos_ram #(.DEPTH(RATE_DEPTH), .WIDTH(RATE_W)) u_rate (
		.clk   (clk),
		.we    (rate_we),
		.waddr (rate_waddr),
		.wdata (rate_wdata),
		.raddr (rate_raddr),
		.rdata (rate_rd)
	);

	`ASSERT_RST(a_done_pulse, done_q |=> !done_q, "result strobe held past one cycle")
	`ASSERT_RST(a_done_after_busy, done_q |-> $past(busy), "result without work in progress")
	`ASSERT_RST(a_walk_degree, (state_q == ST_NBR) |-> (k_q != '0), "neighbour walk on degree zero")
	`ASSERT_RST(a_walk_count, (state_q == ST_NBR) |-> (s_q <= rcv_q && rcv_q <= k_q),
		"neighbour sum out of step")

endmodule

FILE: rtl/sgos_ram.sv
`timescale 1ns / 1ps
module sgos_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 1,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: tb/opinion_sweep_tracker.sv
`timescale 1ns / 1ps
module opinion_sweep_tracker
	import sgos_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              cfg_we,
	input  logic [SITE_W-1:0] cfg_data,
	input  logic [2:0]        req_type,
	input  logic [NODE_W-1:0] node_index,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [NODE_W-1:0] neighbour_index,
	input  logic [DEG_W-1:0]  degree_value,
	input  logic [CNT_W-1:0]  count_value,
	input  logic [RATE_W-1:0] rate_value,
	input  logic              opinion_value,
	input  logic [DRAW_W-1:0] random_draw,
	input  logic              done,
	input  logic              result_kind,
	input  logic [NODE_W-1:0] node_out,
	input  logic              new_opinion,
	input  logic [SITE_W-1:0] active_total,
	output int                mismatches,
	output int                pending
);

	typedef struct packed {
		logic              kind;
		logic [NODE_W-1:0] node;
		logic              opin;
		logic [SITE_W-1:0] total;
	} sweep_out_t;

	logic [NODE_W-1:0] nbr_mem  [NBR_DEPTH];
	logic [DEG_W-1:0]  deg_mem  [NODES];
	logic              cur_op   [NODES];
	logic              nxt_op   [NODES];
	logic [RATE_W-1:0] rate_mem [RATE_DEPTH];
	logic [SITE_W-1:0] sites;
	sweep_out_t        awaited_results[$];

	function automatic int rate_slot(input int k, input int s);
		return s + k * (k + 1) / 2;
	endfunction

	// synchronous rule: sum old opinions of the first k neighbours, activate if draw < rate
	function automatic logic next_opinion_of(input int nd, input logic [DRAW_W-1:0] draw);
		int k;
		int s;
		int w;
		k = deg_mem[nd];
		if (k == 0)
			return cur_op[nd];
		s = 0;
		for (w = 0; w < k; w++)
			s += cur_op[nbr_mem[nd * MAX_DEGREE + w]];
		return (17'(draw) < rate_mem[rate_slot(k, s)]) ? 1'b1 : 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sweep_out_t got;
		sweep_out_t want;
		int i;
		int lim;
		int tot;
		logic op;
		if (!arst_n) begin
			for (i = 0; i < NODES; i++) begin
				deg_mem[i] = '0;
				cur_op[i]  = 1'b0;
				nxt_op[i]  = 1'b0;
			end
			for (i = 0; i < RATE_DEPTH; i++)
				rate_mem[i] = '0;
			sites = SITE_W'(1024);
			awaited_results.delete();
			pending = 0;
		end else begin
			if (done) begin
				got = '{result_kind, node_out, new_opinion, active_total};
				if (awaited_results.size() == 0) begin
					$error("result with no item pending: kind %0d node %0d total %0d",
						result_kind, node_out, active_total);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got.kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, got.kind);
						mismatches++;
					end
					if (got.node !== want.node) begin
						$error("node_out: expected %0d, got %0d", want.node, got.node);
						mismatches++;
					end
					if (got.opin !== want.opin) begin
						$error("new_opinion: expected %0d, got %0d", want.opin, got.opin);
						mismatches++;
					end
					if (got.total !== want.total) begin
						$error("active_total: expected %0d, got %0d", want.total, got.total);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				sites = cfg_data;
			if (start && !busy) begin
				case (req_type)
					REQ_NBR: begin
						nbr_mem[int'(node_index) * MAX_DEGREE + int'(slot_index)] = neighbour_index;
					end
					REQ_DEG: begin
						deg_mem[node_index] = (degree_value > MAX_DEGREE) ?
							DEG_W'(MAX_DEGREE) : degree_value;
					end
					REQ_OPIN: begin
						cur_op[node_index] = opinion_value;
						nxt_op[node_index] = opinion_value;
					end
					REQ_RATE: begin
						if (degree_value <= MAX_DEGREE && count_value <= degree_value)
							rate_mem[rate_slot(degree_value, count_value)] =
								(rate_value > PROB_ONE) ? PROB_ONE : rate_value;
					end
					REQ_UPD: begin
						op = next_opinion_of(node_index, random_draw);
						nxt_op[node_index] = op;
						awaited_results.push_back('{1'b0, node_index, op, '0});
					end
					REQ_COMMIT: begin
						lim = (sites < NODES) ? int'(sites) : NODES;
						tot = 0;
						for (i = 0; i < lim; i++) begin
							cur_op[i] = nxt_op[i];
							tot += cur_op[i];
						end
						awaited_results.push_back('{1'b1, '0, 1'b0, SITE_W'(tot)});
					end
					default: ;
				endcase
			end
			pending = awaited_results.size();
		end
	end

endmodule

FILE: tb/stochastic_graph_opinion_sweep_core_tb.sv
`timescale 1ns / 1ps
module stochastic_graph_opinion_sweep_core_tb;
	import sgos_pkg::*;

	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int ITEMS = 1900;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]        kind;
		logic [NODE_W-1:0] node;
		logic [SLOT_W-1:0] slot;
		logic [NODE_W-1:0] nbr;
		logic [DEG_W-1:0]  deg;
		logic [CNT_W-1:0]  cnt;
		logic [RATE_W-1:0] rate;
		logic              opin;
		logic [DRAW_W-1:0] draw;
	} sweep_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              cfg_we = 1'b0;
	logic [SITE_W-1:0] cfg_data = '0;
	logic [2:0]        req_type = '0;
	logic [NODE_W-1:0] node_index = '0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic [NODE_W-1:0] neighbour_index = '0;
	logic [DEG_W-1:0]  degree_value = '0;
	logic [CNT_W-1:0]  count_value = '0;
	logic [RATE_W-1:0] rate_value = '0;
	logic              opinion_value = 1'b0;
	logic [DRAW_W-1:0] random_draw = '0;
	logic              done;
	logic              result_kind;
	logic [NODE_W-1:0] node_out;
	logic              new_opinion;
	logic [SITE_W-1:0] active_total;
	int                mismatches;
	int                pending;

	// per-node written neighbour slots, to keep updates on written slots
	logic [MAX_DEGREE-1:0] slots_set [NODES];
	int                    counted = 0;
	int                    span = NODES;
	bit                    no_gaps = 1'b0;
	int                    idle_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stochastic_graph_opinion_sweep_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.node_index      (node_index),
		.slot_index      (slot_index),
		.neighbour_index (neighbour_index),
		.degree_value    (degree_value),
		.count_value     (count_value),
		.rate_value      (rate_value),
		.opinion_value   (opinion_value),
		.random_draw     (random_draw),
		.done            (done),
		.result_kind     (result_kind),
		.node_out        (node_out),
		.new_opinion     (new_opinion),
		.active_total    (active_total)
	);

	opinion_sweep_tracker i_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.node_index      (node_index),
		.slot_index      (slot_index),
		.neighbour_index (neighbour_index),
		.degree_value    (degree_value),
		.count_value     (count_value),
		.rate_value      (rate_value),
		.opinion_value   (opinion_value),
		.random_draw     (random_draw),
		.done            (done),
		.result_kind     (result_kind),
		.node_out        (node_out),
		.new_opinion     (new_opinion),
		.active_total    (active_total),
		.mismatches      (mismatches),
		.pending         (pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic sweep_req_t mk(input logic [2:0] kind, input int nd);
		sweep_req_t r;
		r.kind = kind;
		r.node = NODE_W'(nd);
		r.slot = SLOT_W'($urandom);
		r.nbr  = NODE_W'($urandom);
		r.deg  = DEG_W'($urandom);
		r.cnt  = CNT_W'($urandom);
		r.rate = RATE_W'($urandom);
		r.opin = 1'($urandom);
		r.draw = DRAW_W'($urandom);
		return r;
	endfunction

	function automatic int filled_prefix(input int nd);
		int p;
		p = 0;
		while (p < MAX_DEGREE && slots_set[nd][p])
			p++;
		return p;
	endfunction

	function automatic int pick_node();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(0, span - 1) : $urandom_range(0, NODES - 1);
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		int c;
		c = $urandom_range(0, 9);
		if (c == 0)
			return '0;
		if (c == 1)
			return PROB_ONE;
		if (c == 2)
			return RATE_W'($urandom_range(65537, 131071));
		return RATE_W'($urandom_range(0, 65535));
	endfunction

	function automatic int pick_gap();
		int c;
		if (no_gaps)
			return 0;
		c = $urandom_range(0, 99);
		if (c < 65)
			return 0;
		if (c < 93)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	task automatic issue(input sweep_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		req_type        <= r.kind;
		node_index      <= r.node;
		slot_index      <= r.slot;
		neighbour_index <= r.nbr;
		degree_value    <= r.deg;
		count_value     <= r.cnt;
		rate_value      <= r.rate;
		opinion_value   <= r.opin;
		random_draw     <= r.draw;
		do @(negedge clk); while (busy);
		@(posedge clk);
		if (r.kind == REQ_NBR)
			slots_set[r.node][r.slot] = 1'b1;
		counted++;
	endtask

	// wait until every result is back and the block has gone idle
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (24) @(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_sites(input int v);
		cfg_we   <= 1'b1;
		cfg_data <= SITE_W'(v);
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic build_node(input int nd);
		sweep_req_t r;
		int d;
		int w;
		d = $urandom_range(0, MAX_DEGREE);
		for (w = filled_prefix(nd); w < d; w++) begin
			r = mk(REQ_NBR, nd);
			r.slot = SLOT_W'(w);
			r.nbr = NODE_W'(pick_node());
			issue(r);
		end
		r = mk(REQ_DEG, nd);
		r.deg = (d == MAX_DEGREE && $urandom_range(0, 1)) ?
			DEG_W'($urandom_range(MAX_DEGREE + 1, 31)) : DEG_W'(d);
		issue(r);
	endtask

	initial begin
		sweep_req_t r;
		int ep;
		int sc;
		int k;
		int s;
		int p;
		int c;
		for (k = 0; k < NODES; k++) begin
			slots_set[k] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		settle();
		set_sites(NODES);

		// degree-zero nodes keep their opinion
		r = mk(REQ_OPIN, NODES - 1); r.opin = 1'b1; issue(r);
		r = mk(REQ_OPIN, 0); r.opin = 1'b1; issue(r);
		r = mk(REQ_UPD, 5); issue(r);
		r = mk(REQ_UPD, NODES - 1); issue(r);
		// unused codes and out-of-table rate writes are dropped
		r = mk(REQ_SPARE_LO, 3); issue(r);
		r = mk(REQ_SPARE_HI, 4); issue(r);
		r = mk(REQ_RATE, 0); r.deg = 5'd31; r.cnt = 5'd0; issue(r);
		r = mk(REQ_RATE, 0); r.deg = 5'd2; r.cnt = 5'd3; issue(r);
		// rate above one saturates, rate zero never activates
		r = mk(REQ_RATE, 0); r.deg = 5'd1; r.cnt = 5'd0; r.rate = 17'h1FFFF; issue(r);
		r = mk(REQ_RATE, 0); r.deg = 5'd1; r.cnt = 5'd1; r.rate = '0; issue(r);
		r = mk(REQ_NBR, 1); r.slot = 4'd0; r.nbr = NODE_W'(NODES - 1); issue(r);
		r = mk(REQ_NBR, 1); r.slot = 4'd15; r.nbr = '0; issue(r);
		r = mk(REQ_DEG, 1); r.deg = 5'd31; issue(r);
		r = mk(REQ_DEG, 1); r.deg = 5'd1; issue(r);
		r = mk(REQ_UPD, 1); r.draw = '0; issue(r);
		r = mk(REQ_RATE, 0); r.deg = 5'd1; r.cnt = 5'd1; r.rate = PROB_ONE; issue(r);
		r = mk(REQ_UPD, 1); r.draw = 16'hFFFF; issue(r);
		r = mk(REQ_NBR, 2); r.slot = 4'd0; r.nbr = 10'd3; issue(r);
		r = mk(REQ_DEG, 2); r.deg = 5'd1; issue(r);
		r = mk(REQ_UPD, 2); r.draw = 16'hFFFF; issue(r);
		r = mk(REQ_COMMIT, 0); issue(r);
		settle();
		set_sites(0);
		r = mk(REQ_COMMIT, 0); issue(r);
		settle();
		set_sites(2);
		r = mk(REQ_COMMIT, 0); issue(r);

		// fill the whole rate table so every (k, s) lookup is defined
		for (k = 0; k <= MAX_DEGREE; k++)
			for (s = 0; s <= k; s++) begin
				r = mk(REQ_RATE, 0);
				r.deg = DEG_W'(k);
				r.cnt = CNT_W'(s);
				r.rate = pick_rate();
				issue(r);
			end

		ep = 0;
		while (counted < ITEMS) begin
			settle();
			case (ep)
				0: sc = 2047;
				1: sc = 1;
				2: sc = 1024;
				3: sc = 0;
				default: begin
					c = $urandom_range(0, 99);
					if (c < 65)
						sc = $urandom_range(2, 40);
					else if (c < 75)
						sc = $urandom_range(0, 2047);
					else
						case ($urandom_range(0, 5))
							0: sc = 0;
							1: sc = 1;
							2: sc = 1023;
							3: sc = 1024;
							4: sc = 1025;
							default: sc = 2047;
						endcase
				end
			endcase
			set_sites(sc);
			span = (sc + 3 < 4) ? 4 : ((sc + 3 > NODES) ? NODES : sc + 3);
			no_gaps = (ep % 4 == 3);
			repeat (4) build_node(pick_node());
			repeat (60) begin
				c = $urandom_range(0, 99);
				if (c < 45) begin
					r = mk(REQ_UPD, pick_node());
					issue(r);
				end else if (c < 53) begin
					r = mk(REQ_COMMIT, $urandom_range(0, NODES - 1));
					issue(r);
				end else if (c < 64) begin
					r = mk(REQ_OPIN, pick_node());
					issue(r);
				end else if (c < 72) begin
					k = $urandom_range(0, MAX_DEGREE);
					r = mk(REQ_RATE, $urandom_range(0, NODES - 1));
					r.deg = DEG_W'(k);
					r.cnt = CNT_W'($urandom_range(0, k));
					r.rate = pick_rate();
					issue(r);
				end else if (c < 79) begin
					r = mk(REQ_NBR, pick_node());
					r.nbr = NODE_W'(pick_node());
					issue(r);
				end else if (c < 85) begin
					r = mk(REQ_DEG, pick_node());
					p = filled_prefix(r.node);
					r.deg = (p == MAX_DEGREE && $urandom_range(0, 1)) ?
						DEG_W'($urandom_range(MAX_DEGREE + 1, 31)) : DEG_W'($urandom_range(0, p));
					issue(r);
				end else if (c < 90) begin
					build_node(pick_node());
				end else if (c < 95) begin
					r = mk(REQ_RATE, $urandom_range(0, NODES - 1));
					if ($urandom_range(0, 1)) begin
						r.deg = DEG_W'($urandom_range(MAX_DEGREE + 1, 31));
						r.cnt = CNT_W'($urandom_range(0, 31));
					end else begin
						k = $urandom_range(0, MAX_DEGREE - 1);
						r.deg = DEG_W'(k);
						r.cnt = CNT_W'($urandom_range(k + 1, 31));
					end
					issue(r);
				end else begin
					r = mk($urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI, $urandom_range(0, NODES - 1));
					issue(r);
				end
			end
			ep++;
		end

		settle();
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
